/* rtl/sha1_block_compression_macros.svh */
// Assertion macros shared by the SHA-1 block compression modules.
`ifndef SHA1_BLOCK_COMPRESSION_MACROS_SVH
`define SHA1_BLOCK_COMPRESSION_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SHA1BC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SHA1BC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sha1bc_pkg.sv */
// Types, constants and round functions shared by the SHA-1 block compression modules.
package sha1bc_pkg;

    localparam int WORD_W      = 32;
    localparam int WORDS       = 16;
    localparam int WCNT_W      = 4;
    localparam int ROUND_W     = 7;
    localparam int DIGEST_N    = 5;
    localparam int IDX_W       = 3;

    localparam logic [WCNT_W-1:0]  WCNT_LAST  = 4'd15;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;

    // Standard SHA-1 initial chaining value.
    localparam logic [WORD_W-1:0] SHA1_IV [DIGEST_N] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROUND,
        ST_FOLD
    } state_t;

    typedef enum logic [1:0] {
        PH_CHOOSE,
        PH_PARITY_LO,
        PH_MAJORITY,
        PH_PARITY_HI
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load_word;
        logic   restart;
        logic   init_work;
        logic   round_en;
        phase_t phase;
        logic   fold;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } stat_t;

    function automatic logic [WORD_W-1:0] round_mix(
        input phase_t            ph,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] res;
        case (ph)
            PH_CHOOSE:   res = (b & c) | (~b & d);
            PH_MAJORITY: res = (b & c) | (b & d) | (c & d);
            default:     res = b ^ c ^ d;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input phase_t ph);
        logic [WORD_W-1:0] res;
        case (ph)
            PH_CHOOSE:    res = 32'h5a827999;
            PH_PARITY_LO: res = 32'h6ed9eba1;
            PH_MAJORITY:  res = 32'h8f1bbcdc;
            default:      res = 32'hca62c1d6;
        endcase
        return res;
    endfunction

endpackage

/* rtl/sha1bc_ctrl.sv */
// Controller: word counting, round sequencing and input flow control.
`include "sha1_block_compression_macros.svh"

module sha1bc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic                s_axis_tuser,
    input  sha1bc_pkg::stat_t   stat,
    output sha1bc_pkg::cmd_t    cmd
);
    import sha1bc_pkg::*;

    state_t               state_reg, state_next;
    logic [WCNT_W-1:0]    wc_reg, wc_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic                 accept;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            wc_reg    <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            round_reg <= round_next;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        wc_next       = wc_reg;
        round_next    = round_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.phase     = PH_CHOOSE;
        case (state_reg)
            ST_LOAD:
            begin
                // Hold off a block's final request while the previous digest still drains.
                s_axis_tready = !(wc_reg == WCNT_LAST && stat.out_busy);
                if (accept)
                begin
                    cmd.load_word = 1'b1;
                    cmd.restart   = s_axis_tuser;
                    if (s_axis_tuser)
                    begin
                        wc_next = 4'd1;
                    end
                    else
                    begin
                        wc_next = wc_reg + 4'd1;
                        if (wc_reg == WCNT_LAST)
                        begin
                            state_next = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_work = 1'b1;
                round_next    = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg < 7'd20)
                begin
                    cmd.phase = PH_CHOOSE;
                end
                else if (round_reg < 7'd40)
                begin
                    cmd.phase = PH_PARITY_LO;
                end
                else if (round_reg < 7'd60)
                begin
                    cmd.phase = PH_MAJORITY;
                end
                else
                begin
                    cmd.phase = PH_PARITY_HI;
                end
                if (round_reg == ROUND_LAST)
                begin
                    round_next = '0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Checks on the sequencing.
    `SHA1BC_ASSERT_NOW(a_ready_only_loading, s_axis_tready, state_reg == ST_LOAD,
        "input ready outside the loading state")
    `SHA1BC_ASSERT_NOW(a_round_in_range, state_reg == ST_ROUND, round_reg <= ROUND_LAST,
        "round counter beyond the last round")
    `SHA1BC_ASSERT_NEXT(a_fold_returns, state_reg == ST_FOLD,
        state_reg == ST_LOAD && wc_reg == '0 && round_reg == '0,
        "fold not followed by an empty loading state")

endmodule

/* rtl/sha1bc_datapath.sv */
// Datapath: schedule window, round logic, chaining value and digest output buffer.
`include "sha1_block_compression_macros.svh"

module sha1bc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sha1bc_pkg::cmd_t                   cmd,
    output sha1bc_pkg::stat_t                  stat,
    input  logic [sha1bc_pkg::WORD_W-1:0]      message_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sha1bc_pkg::WORD_W-1:0]      digest_word,
    output logic [sha1bc_pkg::IDX_W-1:0]       digest_index,
    output logic                               out_last
);
    import sha1bc_pkg::*;

    logic [WORD_W-1:0] win_reg [WORDS];
    logic [WORD_W-1:0] cv_reg  [DIGEST_N];
    logic [WORD_W-1:0] buf_reg [DIGEST_N];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              valid_reg;
    logic [WORD_W-1:0] sched_mix, win_in, temp_next;
    logic [WORD_W-1:0] fold_sum [DIGEST_N];
    logic              out_take;

    // Next schedule word from the fixed window taps, and what enters the window.
    assign sched_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign win_in    = cmd.load_word ? message_word : {sched_mix[WORD_W-2:0], sched_mix[WORD_W-1]};

    // Round sum: rotated a, round function, e, round constant, current schedule word.
    assign temp_next = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]}
                     + round_mix(cmd.phase, b_reg, c_reg, d_reg)
                     + e_reg + round_const(cmd.phase) + win_reg[0];

    // Final additions into the chaining value.
    assign fold_sum[0] = cv_reg[0] + a_reg;
    assign fold_sum[1] = cv_reg[1] + b_reg;
    assign fold_sum[2] = cv_reg[2] + c_reg;
    assign fold_sum[3] = cv_reg[3] + d_reg;
    assign fold_sum[4] = cv_reg[4] + e_reg;

    // Schedule window: a shift line, oldest word at the bottom tap.
    always_ff @(posedge clk)
    begin
        if (cmd.load_word || cmd.round_en)
        begin
            for (int i = 0; i < WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WORDS-1] <= win_in;
        end
    end

    // Working words.
    always_ff @(posedge clk)
    begin
        if (cmd.init_work)
        begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
            e_reg <= cv_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= temp_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value: restarted by the flag, updated at the end of a block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_N; i++)
            begin
                cv_reg[i] <= SHA1_IV[i];
            end
        end
        else if (cmd.load_word && cmd.restart)
        begin
            for (int i = 0; i < DIGEST_N; i++)
            begin
                cv_reg[i] <= SHA1_IV[i];
            end
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < DIGEST_N; i++)
            begin
                cv_reg[i] <= fold_sum[i];
            end
        end
    end

    assign out_take = valid_reg && out_ready;

    // Digest buffer: shifts down one word per accepted result request.
    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            for (int i = 0; i < DIGEST_N; i++)
            begin
                buf_reg[i] <= fold_sum[i];
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < DIGEST_N - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[DIGEST_N-1] <= buf_reg[DIGEST_N-1];
        end
    end

    // Output valid and index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (cmd.fold)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_take)
        begin
            valid_reg <= (idx_reg != IDX_LAST);
            idx_reg   <= idx_reg + 3'd1;
        end
    end

    assign out_valid     = valid_reg;
    assign digest_word   = buf_reg[0];
    assign digest_index  = idx_reg;
    assign out_last      = (idx_reg == IDX_LAST);
    assign stat.out_busy = valid_reg;

    // Checks on the output buffer.
    `SHA1BC_ASSERT_NOW(a_fold_into_empty, cmd.fold, !valid_reg,
        "digest buffer overwritten before it drained")
    `SHA1BC_ASSERT_NEXT(a_last_ends_run, out_take && idx_reg == IDX_LAST, !valid_reg,
        "results continue past the fifth digest word")

endmodule

/* rtl/sha1_block_compression.sv */
// Top level of the SHA-1 block compression engine.
//
// Input channel s_axis: one 32-bit big-endian message word per request in tdata;
// tuser is set on a new message's first word and restarts the chaining value at the
// SHA-1 initial value (a partly received block is then dropped). Padding and
// length encoding are done by the sender.
// Loading takes one word per cycle unless the input stalls or the sixteenth word
// is held off. After the sixteenth word the block runs a set-up step, then the
// 80 rounds, one per cycle in a single round unit, then a final-addition step;
// the first digest word is valid once that final-addition step is done.
// Output channel m_axis: five requests per block, chaining words 0 to 4, with
// tlast on the fifth. They are held in a buffer, so the next block's words are
// taken while the digest drains; only a block's sixteenth word waits until the
// previous digest has gone. A stalled receiver holds the current word steady.
// Reset restores the initial chaining value, empties the output buffer and
// starts a new block count; the schedule window needs no reset.
module sha1_block_compression (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic        s_axis_tuser,   // [0] new_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index, zero above
    output logic        m_axis_tlast
);
    import sha1bc_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  digest_index;

    sha1bc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    sha1bc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .message_word (s_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .out_last     (m_axis_tlast)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = {5'd0, digest_index, digest_word};

endmodule

/* tb/sha1_block_compression_tb.sv */
// Self-checking testbench for the SHA-1 block compression engine, with its digest scoreboard.
`timescale 1ns / 1ps

// One expected digest request: chaining word, its index and the end-of-digest mark.
typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
} digest_item_t;

// Tracks the chaining value and schedule window as message words are accepted,
// and holds the digest requests that the engine still owes.
class sha1_digest_scoreboard;
    logic [31:0]                   hash_state [sha1bc_pkg::DIGEST_N];
    logic [31:0]                   sched [sha1bc_pkg::WORDS];
    logic [sha1bc_pkg::WCNT_W-1:0] fill;
    digest_item_t                  pending [$];
    int                            words_seen;
    int                            blocks_done;
    int                            restarts;
    int                            aborted;
    int                            results;
    int                            faults;

    function new();
        restore_iv();
        fill        = '0;
        words_seen  = 0;
        blocks_done = 0;
        restarts    = 0;
        aborted     = 0;
        results     = 0;
        faults      = 0;
    endfunction

    function void restore_iv();
        for (int i = 0; i < sha1bc_pkg::DIGEST_N; i++)
        begin
            hash_state[i] = sha1bc_pkg::SHA1_IV[i];
        end
    endfunction

    // Round group: selects the mixing function and the additive constant.
    function sha1bc_pkg::phase_t stage_of(int r);
        if (r < 20)
            return sha1bc_pkg::PH_CHOOSE;
        if (r < 40)
            return sha1bc_pkg::PH_PARITY_LO;
        if (r < 60)
            return sha1bc_pkg::PH_MAJORITY;
        return sha1bc_pkg::PH_PARITY_HI;
    endfunction

    // Eighty rounds over the window, expanding the schedule in place, then the
    // working words are folded into the chaining value.
    function void run_rounds();
        logic [31:0] a, b, c, d, e, t, w, f, k;
        int          s;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++)
        begin
            s = r & 15;
            if (r >= 16)
            begin
                w = sched[(s + 13) & 15] ^ sched[(s + 8) & 15] ^ sched[(s + 2) & 15] ^ sched[s];
                sched[s] = {w[30:0], w[31]};
            end
            case (stage_of(r))
                sha1bc_pkg::PH_CHOOSE:
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5a827999;
                end
                sha1bc_pkg::PH_PARITY_LO:
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ed9eba1;
                end
                sha1bc_pkg::PH_MAJORITY:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8f1bbcdc;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = 32'hca62c1d6;
                end
            endcase
            t = {a[26:0], a[31:27]} + f + e + k + sched[s];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // An accepted message word; the sixteenth of a block queues five digest words.
    function void note_request(logic [31:0] word, logic restart);
        digest_item_t item;
        words_seen++;
        if (restart)
        begin
            restarts++;
            if (fill != '0)
                aborted++;
            restore_iv();
            fill = '0;
        end
        sched[fill] = word;
        fill++;
        if (fill == '0)
        begin
            run_rounds();
            blocks_done++;
            for (int i = 0; i < sha1bc_pkg::DIGEST_N; i++)
            begin
                item.word    = hash_state[i];
                item.idx     = i[2:0];
                item.is_last = (item.idx == sha1bc_pkg::IDX_LAST);
                pending.push_back(item);
            end
        end
    endfunction

    function void flag_fault(string what, logic [31:0] exp_v, logic [31:0] got_v);
        faults++;
        if (faults <= 10)
            $display("%0t: digest mismatch (%s): expected %h, got %h", $realtime, what,
                     exp_v, got_v);
    endfunction

    // An accepted digest request, compared with the oldest one outstanding.
    function void check_request(logic [31:0] word, logic [2:0] idx, logic is_last,
                                logic [4:0] pad);
        digest_item_t item;
        results++;
        if (pending.size() == 0)
        begin
            flag_fault("digest word with none outstanding", '0, word);
        end
        else
        begin
            item = pending.pop_front();
            if (word !== item.word)
                flag_fault("digest_word", item.word, word);
            if (idx !== item.idx)
                flag_fault("digest_index", 32'(item.idx), 32'(idx));
            if (is_last !== item.is_last)
                flag_fault("last", 32'(item.is_last), 32'(is_last));
            if (pad !== 5'd0)
                flag_fault("bits above digest_index", '0, 32'(pad));
        end
    endfunction
endclass

module sha1_block_compression_tb;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data  = '0;
    logic        s_flag  = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic        m_last;

    bit          tx_quiet = 1'b0;

    sha1_digest_scoreboard digests = new();

    sha1_block_compression i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_flag),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    // Free-running 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Message word biased towards the all-zero and all-one extremes.
    function automatic logic [31:0] rand_word();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Offers one message word after a random idle spell and waits for acceptance.
    task automatic send_word(input logic [31:0] word, input logic restart);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            s_data  <= $urandom;
            s_flag  <= 1'($urandom_range(1));
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        s_flag  <= restart;
        do
            @(posedge clk);
        while (!s_ready);
        digests.note_request(word, restart);
    endtask

    // Receiver: checks each accepted digest request and stalls at random, with
    // spells of constant readiness in between.
    initial
    begin
        int stall;
        int mode_left;
        bit rx_quiet;
        stall     = 0;
        mode_left = 100;
        rx_quiet  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_valid && m_ready)
                digests.check_request(m_data[31:0], m_data[34:32], m_last, m_data[39:35]);
            if (stall == 0 && !rx_quiet && $urandom_range(3) == 0)
                stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                m_ready <= 1'b0;
                stall = stall - 1;
            end
            else
            begin
                m_ready <= 1'b1;
            end
            mode_left = mode_left - 1;
            if (mode_left <= 0)
            begin
                rx_quiet  = ($urandom_range(3) == 0);
                mode_left = $urandom_range(50, 400);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [31:0] corner_words [8];
        int          len;
        int          rand_items;
        int          guard;
        logic        head_flag;
        bit          first_block;
        corner_words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                         32'h7fff_ffff, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A block straight after reset without the restart flag, so it chains
        // from the initial value; the extreme word values lead it.
        for (int i = 0; i < 16; i++)
            send_word((i < 8) ? corner_words[i] : rand_word(), 1'b0);

        // A partial block; the first random block restarts in the middle of it.
        for (int i = 0; i < 4; i++)
            send_word(rand_word(), i == 0);

        // Mostly whole blocks, some chained and some restarted, with the odd
        // truncated block and a rare stray restart in the middle of a block.
        rand_items  = 0;
        first_block = 1'b1;
        while (rand_items < 250)
        begin
            tx_quiet    = ($urandom_range(3) == 0);
            len         = ($urandom_range(11) == 0) ? $urandom_range(1, 15) : 16;
            head_flag   = first_block ? 1'b1 : 1'($urandom_range(1));
            first_block = 1'b0;
            for (int n = 0; n < len; n++)
                send_word(rand_word(), (n == 0) ? head_flag : ($urandom_range(63) == 0));
            rand_items += len;
        end
        s_valid <= 1'b0;

        // Drain the outstanding digests, then allow a compression's latency for
        // anything spurious to appear.
        guard = 0;
        while (digests.pending.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        if (digests.pending.size() != 0)
        begin
            $display("%0d digest words never arrived", digests.pending.size());
            $display("sha1_block_compression regression: fail");
            $finish;
        end
        else
        begin
            repeat (120) @(posedge clk);
            $display("Covered %0d message words over %0d compressed blocks, %0d restarts of %0d %s",
                     digests.words_seen, digests.blocks_done, digests.restarts, digests.aborted,
                     "abandoned a partial block.");
            $display("Checked %0d digest words; %0d faults found.", digests.results,
                     digests.faults);
            if (digests.faults == 0)
                $display("sha1_block_compression regression: pass");
            else
                $display("sha1_block_compression regression: fail");
            $finish;
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #10_000_000;
        $display("Watchdog expired with %0d digest words outstanding",
                 digests.pending.size());
        $display("sha1_block_compression regression: fail");
        $finish;
    end

endmodule

/* sha1_block_compression.f */
+incdir+rtl
rtl/sha1bc_pkg.sv
rtl/sha1bc_ctrl.sv
rtl/sha1bc_datapath.sv
rtl/sha1_block_compression.sv
tb/sha1_block_compression_tb.sv
